// File: rtl/core/escd_pkg.sv
package escd_pkg;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_esc;

    function automatic t_esc esc_map(input logic [7:0] c);
        t_esc r;
        r.hit  = 1'b1;
        r.code = CH_NUL;
        unique case (c)
            CH_ZERO:      r.code = CH_NUL;
            CH_BACKSLASH: r.code = CH_BACKSLASH;
            CH_SQUOTE:    r.code = CH_SQUOTE;
            CH_DQUOTE:    r.code = CH_DQUOTE;
            CH_N:         r.code = CH_LF;
            CH_R:         r.code = CH_CR;
            CH_T:         r.code = CH_TAB;
            default:      r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/escd_front.sv
module escd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    input  logic            i_q_full,
    output logic            o_push,
    output escd_pkg::t_entry o_push_data
);
    import escd_pkg::*;

    logic       r_at_start;
    logic       r_pending;
    logic       r_sec_valid;
    t_entry     r_sec;
    logic       n_pending;
    logic [1:0] n_count;
    logic [7:0] n_b0;
    logic [7:0] n_b1;
    logic       accept;
    t_esc       esc;
    t_entry     e0;
    t_entry     e1;

    always_comb begin
        esc       = esc_map(i_in_byte);
        n_pending = r_pending;
        n_count   = 2'd0;
        n_b0      = CH_NUL;
        n_b1      = CH_NUL;
        if (r_at_start && i_in_byte == CH_DQUOTE) begin
            n_pending = 1'b0;
        end else if (r_pending) begin
            n_pending = 1'b0;
            if (esc.hit) begin
                n_count = 2'd1;
                n_b0    = esc.code;
            end else begin
                n_count = 2'd2;
                n_b0    = CH_BACKSLASH;
                n_b1    = i_in_byte;
            end
        end else if (i_in_byte == CH_BACKSLASH) begin
            n_pending = 1'b1;
        end else begin
            n_count = 2'd1;
            n_b0    = i_in_byte;
        end
        if (i_in_last && n_pending) begin
            n_count = 2'd1;
            n_b0    = CH_BACKSLASH;
        end
        e0.data     = n_b0;
        e0.has_byte = (n_count != 2'd0);
        e0.last     = i_in_last && (n_count != 2'd2);
        e1.data     = n_b1;
        e1.has_byte = 1'b1;
        e1.last     = i_in_last;
    end

    assign o_in_stall  = r_sec_valid || i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = (accept && (n_count != 2'd0 || i_in_last))
                         || (r_sec_valid && !i_q_full);
    assign o_push_data = r_sec_valid ? r_sec : e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_pending   <= 1'b0;
            r_sec_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_at_start  <= i_in_last;
                r_pending   <= i_in_last ? 1'b0 : n_pending;
                r_sec_valid <= (n_count == 2'd2);
            end else if (r_sec_valid && !i_q_full) begin
                r_sec_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sec <= e1;
        end
    end

    a_pending_not_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> !r_at_start)
        else $error("pending backslash at string start");

    a_sec_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec_valid && !i_q_full) |=> !r_sec_valid)
        else $error("second word not drained");

endmodule

// File: rtl/core/escd_queue.sv
module escd_queue #(
    parameter int DEPTH = escd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  escd_pkg::t_entry i_push_data,
    output logic             o_full,
    output logic             o_valid,
    output escd_pkg::t_entry o_data,
    input  logic             i_pop
);
    import escd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

// File: rtl/core/escd_back.sv
module escd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  escd_pkg::t_entry i_q_data,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic             o_out_empty
);
    import escd_pkg::*;

    logic       r_held_valid;
    logic [7:0] r_held_char;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_empty;
    logic       r_tail_valid;
    logic [7:0] r_tail_byte;
    logic       r_tail_empty;

    logic       load_ok;
    logic       emit_a;
    logic       emit_b;
    logic       n_held_valid;
    logic [7:0] n_held_char;

    assign load_ok = !r_out_valid || !i_out_stall;
    assign o_pop   = i_q_valid && load_ok && !r_tail_valid;

    always_comb begin
        emit_a       = i_q_data.has_byte && r_held_valid;
        n_held_valid = r_held_valid || i_q_data.has_byte;
        n_held_char  = i_q_data.has_byte ? i_q_data.data : r_held_char;
        emit_b       = i_q_data.last && n_held_valid && (n_held_char != CH_DQUOTE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            if (r_tail_valid && load_ok) begin
                r_out_valid  <= 1'b1;
                r_tail_valid <= 1'b0;
            end else if (o_pop) begin
                r_held_valid <= i_q_data.last ? 1'b0 : n_held_valid;
                r_out_valid  <= emit_a || i_q_data.last;
                r_tail_valid <= emit_a && emit_b;
            end else if (load_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tail_valid && load_ok) begin
            r_out_byte  <= r_tail_byte;
            r_out_last  <= 1'b1;
            r_out_empty <= r_tail_empty;
        end else if (o_pop) begin
            r_held_char <= n_held_char;
            if (emit_a) begin
                r_out_byte  <= r_held_char;
                r_out_last  <= i_q_data.last && !emit_b;
                r_out_empty <= 1'b0;
                r_tail_byte <= n_held_char;
                r_tail_empty <= 1'b0;
            end else begin
                r_out_byte  <= emit_b ? n_held_char : CH_NUL;
                r_out_last  <= 1'b1;
                r_out_empty <= !emit_b;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_empty = r_out_empty;

    a_tail_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_valid |-> r_out_valid)
        else $error("tail word without output word");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty marker without last mark");

    a_no_pop_with_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_valid |-> !o_pop)
        else $error("queue popped while tail word waits");

endmodule

// File: rtl/core/escape_sequence_decoder.sv
// A result from an accepted word passes the queue, then the output register.
// Throughput: one input word per cycle while the queue has room, but an escape
// not recognized yields two decoded bytes and stalls input until both are queued.
// The back end emits one result per cycle unless the output stalls; a last word may
// release up to three results; a last entry with two holds one in a tail register.
// Reset is synchronous, active low, and clears all control state; no clearing pass.
module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = escd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_empty
);
    import escd_pkg::*;

    logic   q_full;
    logic   q_push;
    t_entry q_push_data;
    logic   q_valid;
    t_entry q_data;
    logic   q_pop;

    escd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    escd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    escd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_empty (o_out_empty)
    );

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import escd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } t_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h01;
    logic       i_in_last   = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_empty;

    t_result     decoded_q[$];
    t_result     step_q[$];
    t_result     got_res;
    logic [7:0]  lit_q[$];
    logic        str_begin   = 1'b1;
    logic        esc_wait    = 1'b0;
    logic        hold_full   = 1'b0;
    logic [7:0]  hold_char   = CH_NUL;
    int unsigned fail_cnt    = 0;
    int unsigned burst_left  = 0;
    logic [9:0]  stall_phase = '0;

    escape_sequence_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_empty (o_out_empty)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic t_result make_result(input logic [7:0] d, input logic l,
                                            input logic e);
        t_result r;
        r.data  = d;
        r.last  = l;
        r.empty = e;
        return r;
    endfunction

    // Returns the hit flag in the top bit and the decoded byte below it.
    function automatic logic [8:0] escape_code(input logic [7:0] c);
        case (c)
            CH_ZERO:      return {1'b1, CH_NUL};
            CH_BACKSLASH: return {1'b1, CH_BACKSLASH};
            CH_SQUOTE:    return {1'b1, CH_SQUOTE};
            CH_DQUOTE:    return {1'b1, CH_DQUOTE};
            CH_N:         return {1'b1, CH_LF};
            CH_R:         return {1'b1, CH_CR};
            CH_T:         return {1'b1, CH_TAB};
            default:      return {1'b0, CH_NUL};
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(6, 0))
            0:       return CH_ZERO;
            1:       return CH_BACKSLASH;
            2:       return CH_SQUOTE;
            3:       return CH_DQUOTE;
            4:       return CH_N;
            5:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (hold_full) begin
            step_q = {step_q, make_result(hold_char, 1'b0, 1'b0)};
        end
        hold_char = b;
        hold_full = 1'b1;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic l);
        logic       opening;
        logic [8:0] esc;
        t_result    r;
        opening   = str_begin;
        str_begin = 1'b0;
        step_q.delete();
        if (!(opening && c == CH_DQUOTE)) begin
            if (esc_wait) begin
                esc_wait = 1'b0;
                esc = escape_code(c);
                if (esc[8]) begin
                    hold_byte(esc[7:0]);
                end else begin
                    hold_byte(CH_BACKSLASH);
                    if (c == CH_BACKSLASH) begin
                        esc_wait = 1'b1;
                    end else begin
                        hold_byte(c);
                    end
                end
            end else if (c == CH_BACKSLASH) begin
                esc_wait = 1'b1;
            end else begin
                hold_byte(c);
            end
        end
        if (l) begin
            if (esc_wait) begin
                hold_byte(CH_BACKSLASH);
            end
            if (hold_full && hold_char != CH_DQUOTE) begin
                step_q = {step_q, make_result(hold_char, 1'b0, 1'b0)};
            end
            if (step_q.size() == 0) begin
                step_q = {step_q, make_result(CH_NUL, 1'b1, 1'b1)};
            end else begin
                r = step_q[$];
                r.last = 1'b1;
                step_q[$] = r;
            end
            str_begin = 1'b1;
            esc_wait  = 1'b0;
            hold_full = 1'b0;
            hold_char = CH_NUL;
        end
        while (step_q.size() != 0) begin
            decoded_q = {decoded_q, step_q.pop_front()};
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (decoded_q.size() == 0) begin
                if (fail_cnt < 10) begin
                    $display("unexpected word: byte %h last %b empty %b",
                             o_out_byte, o_out_last, o_out_empty);
                end
                fail_cnt++;
            end else begin
                got_res = decoded_q.pop_front();
                if (o_out_last !== got_res.last || o_out_empty !== got_res.empty
                        || (!got_res.empty && o_out_byte !== got_res.data)) begin
                    if (fail_cnt < 10) begin
                        $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 got_res.data, got_res.last, got_res.empty,
                                 o_out_byte, o_out_last, o_out_empty);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(3, 0) == 0);
            2'd2:    i_out_stall <= ($urandom_range(3, 0) != 0);
            default: i_out_stall <= (stall_phase[2:0] < 3'd3);
        endcase
    end

    task automatic send_word(input logic [7:0] b, input logic l);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        decode_char(b, l);
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(3, 0) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_literal();
        for (int k = 0; k < lit_q.size(); k++) begin
            send_word(lit_q[k], k == lit_q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (decoded_q.size() != 0);
    endtask

    task automatic test_empty_strings();
        lit_q = '{CH_DQUOTE};
        send_literal();
        lit_q = '{CH_DQUOTE, CH_DQUOTE};
        send_literal();
        lit_q = '{CH_DQUOTE, "a", CH_DQUOTE};
        send_literal();
    endtask

    task automatic test_escapes();
        lit_q = '{CH_BACKSLASH, CH_ZERO, CH_BACKSLASH, CH_BACKSLASH,
                  CH_BACKSLASH, CH_SQUOTE, CH_BACKSLASH, CH_N,
                  CH_BACKSLASH, CH_R, CH_BACKSLASH, CH_T,
                  CH_BACKSLASH, "q", CH_BACKSLASH, CH_DQUOTE};
        send_literal();
    endtask

    task automatic test_extreme_bytes();
        lit_q = '{8'h01, 8'hFF, CH_BACKSLASH};
        send_literal();
    endtask

    task automatic test_random_literals();
        int unsigned sent;
        int unsigned n;
        int unsigned pick;
        sent = 0;
        while (sent < 405) begin
            lit_q.delete();
            if ($urandom_range(4, 0) == 0) begin
                n = $urandom_range(8, 1);
                repeat (n) begin
                    case ($urandom_range(3, 0))
                        0:       lit_q = {lit_q, CH_BACKSLASH};
                        1:       lit_q = {lit_q, CH_DQUOTE};
                        default: lit_q = {lit_q, 8'($urandom_range(255, 1))};
                    endcase
                end
            end else begin
                if ($urandom_range(9, 0) != 0) begin
                    lit_q = {lit_q, CH_DQUOTE};
                end
                n = $urandom_range(10, 0);
                repeat (n) begin
                    case ($urandom_range(4, 0))
                        0, 1: begin
                            lit_q = {lit_q, CH_BACKSLASH};
                            lit_q = {lit_q, pick_escape()};
                        end
                        2: begin
                            lit_q = {lit_q, CH_BACKSLASH};
                            lit_q = {lit_q, 8'($urandom_range(255, 1))};
                        end
                        default: lit_q = {lit_q, 8'($urandom_range(255, 1))};
                    endcase
                end
                pick = $urandom_range(9, 0);
                if (pick < 8) begin
                    lit_q = {lit_q, CH_DQUOTE};
                end else if (pick == 8) begin
                    lit_q = {lit_q, CH_BACKSLASH};
                end
                if (lit_q.size() == 0) begin
                    lit_q = {lit_q, 8'($urandom_range(255, 1))};
                end
            end
            sent += lit_q.size();
            send_literal();
            if ($urandom_range(15, 0) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_strings();
        test_escapes();
        test_extreme_bytes();
        wait_drained();
        test_random_literals();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && decoded_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/escd_pkg.sv
rtl/core/escd_front.sv
rtl/core/escd_queue.sv
rtl/core/escd_back.sv
rtl/core/escape_sequence_decoder.sv
tb/tb.sv
